FILE: sv/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg: shared types and constants for satellite azimuth/elevation
// Fixed-point formats, configuration register indexes, arctangent table and
// the coefficient bundle passed from the trig unit to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

  // Internal angle width, units of 2^-24 degree
  localparam int Z_W    = 35;
  // Q30 sine/cosine and product width
  localparam int TRIG_W = 33;
  // Vectoring datapath width (Q8 metres plus growth)
  localparam int VEC_W  = 40;
  // East/north/up width, Q8 metres
  localparam int ENU_W  = 38;
  // Satellite minus receiver difference width
  localparam int D_W    = 28;

  localparam logic signed [Z_W-1:0] HALF_TURN    = 35'sd3019898880;
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 35'sd1509949440;
  localparam logic signed [Z_W-1:0] FULL_TURN    = 35'sd6039797760;
  localparam logic signed [Z_W-1:0] ROUND_HALF   = 35'sd128;

  localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic [23:0]              GAIN_Q24 = 24'd10188014;

  localparam logic signed [26:0] FULL_TURN_16 = 27'sd23592960;
  localparam logic signed [26:0] RIGHT_16     = 27'sd5898240;

  // Configuration register indexes
  localparam logic [2:0] REG_RX   = 3'd0;
  localparam logic [2:0] REG_RY   = 3'd1;
  localparam logic [2:0] REG_RZ   = 3'd2;
  localparam logic [2:0] REG_LAT  = 3'd3;
  localparam logic [2:0] REG_LON  = 3'd4;
  localparam logic [2:0] REG_MASK = 3'd5;

  localparam logic [22:0] MASK_RESET = 23'd655360;

  // Rotation coefficients for ECEF to ENU
  typedef struct packed {
    logic signed [TRIG_W-1:0] sl;
    logic signed [TRIG_W-1:0] cl;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] spcl;
    logic signed [TRIG_W-1:0] spsl;
    logic signed [TRIG_W-1:0] cpcl;
    logic signed [TRIG_W-1:0] cpsl;
  } sae_coef_t;

  // Trig unit sequencer states
  typedef enum logic [1:0] {
    CF_LOAD,
    CF_ROT,
    CF_MUL,
    CF_DONE
  } coef_state_t;

  // atan(2^-i) in degrees times 2^24
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] r;
    case (idx)
      5'd0:  r = 35'sd754974720;
      5'd1:  r = 35'sd445687602;
      5'd2:  r = 35'sd235489089;
      5'd3:  r = 35'sd119537938;
      5'd4:  r = 35'sd60000934;
      5'd5:  r = 35'sd30029717;
      5'd6:  r = 35'sd15018523;
      5'd7:  r = 35'sd7509720;
      5'd8:  r = 35'sd3754917;
      5'd9:  r = 35'sd1877466;
      5'd10: r = 35'sd938734;
      5'd11: r = 35'sd469367;
      5'd12: r = 35'sd234684;
      5'd13: r = 35'sd117342;
      5'd14: r = 35'sd58671;
      5'd15: r = 35'sd29335;
      5'd16: r = 35'sd14668;
      5'd17: r = 35'sd7334;
      5'd18: r = 35'sd3667;
      5'd19: r = 35'sd1833;
      5'd20: r = 35'sd917;
      5'd21: r = 35'sd458;
      5'd22: r = 35'sd229;
      5'd23: r = 35'sd115;
      5'd24: r = 35'sd57;
      5'd25: r = 35'sd29;
      5'd26: r = 35'sd14;
      5'd27: r = 35'sd7;
      5'd28: r = 35'sd4;
      5'd29: r = 35'sd2;
      5'd30: r = 35'sd1;
      default: r = 35'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sae_in_if.sv
// ----------------------------------------------------------------------------
// sae_in_if: satellite position channel
// Valid/ready channel carrying one satellite id and ECEF position per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sae_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         sat_id;
  logic signed [26:0] sat_x;
  logic signed [26:0] sat_y;
  logic signed [26:0] sat_z;

  modport source (output valid, sat_id, sat_x, sat_y, sat_z, input ready);
  modport sink   (input valid, sat_id, sat_x, sat_y, sat_z, output ready);
endinterface

`default_nettype wire

FILE: sv/sae_out_if.sv
// ----------------------------------------------------------------------------
// sae_out_if: azimuth/elevation result channel
// Valid/ready channel carrying one look-angle result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sae_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         out_sat_id;
  logic signed [23:0] elevation;
  logic [24:0]        azimuth;
  logic               visible;

  modport source (output valid, out_sat_id, elevation, azimuth, visible, input ready);
  modport sink   (input valid, out_sat_id, elevation, azimuth, visible, output ready);
endinterface

`default_nettype wire

FILE: sv/sae_coef.sv
// ----------------------------------------------------------------------------
// sae_coef: receiver rotation coefficient unit
// Iterative rotation CORDIC for sin/cos of latitude then longitude, followed
// by four cross products on one multiplier. Reruns after reset and after any
// latitude or longitude write; coef_ok is low while it runs.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_coef #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     restart,
  input  wire logic signed [24:0] latitude,
  input  wire logic signed [24:0] longitude,
  output sae_pkg::sae_coef_t      coef,
  output logic                    coef_ok
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int TW    = sae_pkg::TRIG_W;
  localparam int ZW    = sae_pkg::Z_W;

  sae_pkg::coef_state_t state, state_next;

  logic                 sel;        // 0: latitude, 1: longitude
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           mul_idx;
  logic signed [TW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic                 neg;

  logic signed [24:0]   ang;
  logic signed [ZW-1:0] z0, z1, z2;
  logic                 neg0;
  logic signed [TW-1:0] nx, ny;
  logic [4:0]           step;
  logic                 last_step;
  logic signed [TW-1:0] ma, mb;
  logic signed [2*TW-1:0] prod;

  // Angle preparation: scale to 2^-24 deg, wrap once, fold into +-90 deg
  always_comb begin
    ang  = sel ? longitude : latitude;
    z0   = $signed({{(ZW-33){ang[24]}}, ang, 8'b0});
    if (z0 > sae_pkg::HALF_TURN) begin
      z1 = z0 - sae_pkg::FULL_TURN;
    end else if (z0 < -sae_pkg::HALF_TURN) begin
      z1 = z0 + sae_pkg::FULL_TURN;
    end else begin
      z1 = z0;
    end
    neg0 = 1'b0;
    z2   = z1;
    if (z1 > sae_pkg::QUARTER_TURN) begin
      z2   = z1 - sae_pkg::HALF_TURN;
      neg0 = 1'b1;
    end else if (z1 < -sae_pkg::QUARTER_TURN) begin
      z2   = z1 + sae_pkg::HALF_TURN;
      neg0 = 1'b1;
    end
  end

  // One rotation iteration
  always_comb begin
    step      = 5'(cnt);
    last_step = (cnt == CNT_W'(CORDIC_STEPS - 1));
    if (!z[ZW-1]) begin
      nx = x - (y >>> step);
      ny = y + (x >>> step);
    end else begin
      nx = x + (y >>> step);
      ny = y - (x >>> step);
    end
  end

  // Cross product operand select
  always_comb begin
    ma   = mul_idx[1] ? coef.cp : coef.sp;
    mb   = mul_idx[0] ? coef.sl : coef.cl;
    prod = (2*TW)'(ma) * (2*TW)'(mb);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      sae_pkg::CF_LOAD: state_next = sae_pkg::CF_ROT;
      sae_pkg::CF_ROT: begin
        if (last_step) begin
          state_next = sel ? sae_pkg::CF_MUL : sae_pkg::CF_LOAD;
        end
      end
      sae_pkg::CF_MUL: begin
        if (mul_idx == 2'd3) begin
          state_next = sae_pkg::CF_DONE;
        end
      end
      sae_pkg::CF_DONE: state_next = sae_pkg::CF_DONE;
      default: state_next = sae_pkg::CF_LOAD;
    endcase
    if (restart) begin
      state_next = sae_pkg::CF_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sae_pkg::CF_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sel     <= 1'b0;
      cnt     <= '0;
      mul_idx <= '0;
    end else begin
      case (state)
        sae_pkg::CF_LOAD: cnt <= '0;
        sae_pkg::CF_ROT: begin
          cnt <= cnt + 1'b1;
          if (last_step) begin
            sel     <= 1'b1;
            mul_idx <= '0;
          end
        end
        sae_pkg::CF_MUL: mul_idx <= mul_idx + 1'b1;
        default: ;
      endcase
    end
  end

  // CORDIC datapath and coefficient registers
  always_ff @(posedge clk) begin
    case (state)
      sae_pkg::CF_LOAD: begin
        x   <= sae_pkg::GAIN_Q30;
        y   <= '0;
        z   <= z2;
        neg <= neg0;
      end
      sae_pkg::CF_ROT: begin
        x <= nx;
        y <= ny;
        z <= z - (z[ZW-1] ? -sae_pkg::atan_entry(step) : sae_pkg::atan_entry(step));
        if (last_step) begin
          if (!sel) begin
            coef.cp <= neg ? -nx : nx;
            coef.sp <= neg ? -ny : ny;
          end else begin
            coef.cl <= neg ? -nx : nx;
            coef.sl <= neg ? -ny : ny;
          end
        end
      end
      sae_pkg::CF_MUL: begin
        case (mul_idx)
          2'd0: coef.spcl <= prod[TW+29:30];
          2'd1: coef.spsl <= prod[TW+29:30];
          2'd2: coef.cpcl <= prod[TW+29:30];
          default: coef.cpsl <= prod[TW+29:30];
        endcase
      end
      default: ;
    endcase
  end

  assign coef_ok = (state == sae_pkg::CF_DONE);

endmodule

`default_nettype wire

FILE: sv/sae_vec_cordic.sv
// ----------------------------------------------------------------------------
// sae_vec_cordic: pipelined vectoring CORDIC
// One register stage for the left-half fold and zero detect, then one stage
// per iteration. Returns atan2(y, x) in 2^-24 degree and the gained magnitude,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_vec_cordic #(
  parameter int STEPS  = 24,
  parameter int SIDE_W = 8
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    en,
  input  wire                                    in_valid,
  input  wire logic signed [sae_pkg::VEC_W-1:0]  in_x,
  input  wire logic signed [sae_pkg::VEC_W-1:0]  in_y,
  input  wire logic [SIDE_W-1:0]                 in_side,
  output logic                                   out_valid,
  output logic signed [sae_pkg::Z_W-1:0]         out_z,
  output logic signed [sae_pkg::VEC_W-1:0]       out_mag,
  output logic [SIDE_W-1:0]                      out_side
);

  localparam int VW = sae_pkg::VEC_W;
  localparam int ZW = sae_pkg::Z_W;

  logic                 v_r    [0:STEPS];
  logic                 zero_r [0:STEPS];
  logic signed [VW-1:0] x_r    [0:STEPS];
  logic signed [VW-1:0] y_r    [0:STEPS];
  logic signed [ZW-1:0] z_r    [0:STEPS];
  logic [SIDE_W-1:0]    side_r [0:STEPS];

  // Entry stage: fold left half-plane by 180 degrees
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
      if (in_x[VW-1]) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= in_y[VW-1] ? -sae_pkg::HALF_TURN : sae_pkg::HALF_TURN;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  // Iteration stages
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
        if (!y_r[i][VW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + sae_pkg::atan_entry(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - sae_pkg::atan_entry(5'(i));
        end
      end
    end
  end

  // Satellite at the origin gives angle and magnitude zero
  assign out_valid = v_r[STEPS];
  assign out_z     = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign out_mag   = zero_r[STEPS] ? '0 : x_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

`default_nettype wire

FILE: sv/satellite_azimuth_elevation_top.sv
// ----------------------------------------------------------------------------
// satellite_azimuth_elevation_top: ECEF to local azimuth/elevation
// Usage:
//   sat_in carries one satellite item (id, ECEF x/y/z in metres); res_out
//   returns one result per item (id, elevation, azimuth, visible flag), in
//   order. Angles are in units of 2^-16 degree.
//   The configuration port writes receiver position, latitude, longitude and
//   elevation mask by index; write only while no item is in flight.
//   The pipeline has three stages for difference, rotation products and sums,
//   two pipelined vectoring CORDIC chains of CORDIC_STEPS + 1 stages each,
//   two stages for the horizontal-length multiply and one output register.
//   Throughput is one item per cycle while res_out.ready is not held low
//   and the trig unit is not running.
//   After reset, and after each latitude or longitude write, the trig unit
//   runs and sat_in.ready stays low until it is done.
//   When the receiver holds res_out.ready low with a result waiting, the
//   whole pipeline holds and sat_in.ready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module satellite_azimuth_elevation_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [24:0] cfg_data,
  sae_in_if.sink           sat_in,
  sae_out_if.source        res_out
);

  localparam int VW   = sae_pkg::VEC_W;
  localparam int ZW   = sae_pkg::Z_W;
  localparam int TW   = sae_pkg::TRIG_W;
  localparam int EW   = sae_pkg::ENU_W;
  localparam int DW   = sae_pkg::D_W;
  localparam int PW   = TW + DW;
  localparam int SW   = PW + 2;
  localparam int AZ_SIDE = 8 + EW;
  localparam int EL_SIDE = 8 + 25;
  localparam int HLF  = 19;
  localparam int MPW  = HLF + 24;

  // Configuration registers
  logic signed [23:0] rx, ry, rz, lat;
  logic signed [24:0] lon;
  logic [22:0]        mask;
  logic               coef_restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx   <= '0;
      ry   <= '0;
      rz   <= '0;
      lat  <= '0;
      lon  <= '0;
      mask <= sae_pkg::MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sae_pkg::REG_RX:   rx   <= cfg_data[23:0];
        sae_pkg::REG_RY:   ry   <= cfg_data[23:0];
        sae_pkg::REG_RZ:   rz   <= cfg_data[23:0];
        sae_pkg::REG_LAT:  lat  <= cfg_data[23:0];
        sae_pkg::REG_LON:  lon  <= cfg_data;
        sae_pkg::REG_MASK: mask <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  assign coef_restart = cfg_we &&
                        ((cfg_index == sae_pkg::REG_LAT) || (cfg_index == sae_pkg::REG_LON));

  // Rotation coefficients
  sae_pkg::sae_coef_t coef;
  logic               coef_ok;

  sae_coef #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_coef (
    .clk      (clk),
    .rst      (rst),
    .restart  (coef_restart),
    .latitude ({lat[23], lat}),
    .longitude(lon),
    .coef     (coef),
    .coef_ok  (coef_ok)
  );

  // Global pipeline advance: output register empty or being taken
  logic adv;
  logic v6;
  assign adv          = !v6 || res_out.ready;
  assign sat_in.ready = adv && coef_ok;

  // Stage 1: satellite minus receiver
  logic               v1;
  logic [7:0]         id1;
  logic signed [DW-1:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= sat_in.valid && coef_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id1 <= sat_in.sat_id;
      dx  <= DW'(sat_in.sat_x) - DW'(rx);
      dy  <= DW'(sat_in.sat_y) - DW'(ry);
      dz  <= DW'(sat_in.sat_z) - DW'(rz);
    end
  end

  // Stage 2: rotation products
  logic               v2;
  logic [7:0]         id2;
  logic signed [PW-1:0] pe_x, pe_y, pn_x, pn_y, pn_z, pu_x, pu_y, pu_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id2  <= id1;
      pe_x <= PW'(coef.sl)   * PW'(dx);
      pe_y <= PW'(coef.cl)   * PW'(dy);
      pn_x <= PW'(coef.spcl) * PW'(dx);
      pn_y <= PW'(coef.spsl) * PW'(dy);
      pn_z <= PW'(coef.cp)   * PW'(dz);
      pu_x <= PW'(coef.cpcl) * PW'(dx);
      pu_y <= PW'(coef.cpsl) * PW'(dy);
      pu_z <= PW'(coef.sp)   * PW'(dz);
    end
  end

  // Stage 3: east, north, up sums to Q8 metres
  logic               v3;
  logic [7:0]         id3;
  logic signed [EW-1:0] e3, n3, u3;
  logic signed [SW-1:0] e_sum, n_sum, u_sum;

  always_comb begin
    e_sum = -SW'(pe_x) + SW'(pe_y);
    n_sum = -SW'(pn_x) - SW'(pn_y) + SW'(pn_z);
    u_sum = SW'(pu_x) + SW'(pu_y) + SW'(pu_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id3 <= id2;
      e3  <= e_sum[EW+21:22];
      n3  <= n_sum[EW+21:22];
      u3  <= u_sum[EW+21:22];
    end
  end

  // Azimuth chain: atan2(east, north) and horizontal magnitude
  logic                 va;
  logic signed [ZW-1:0] za;
  logic signed [VW-1:0] maga;
  logic [AZ_SIDE-1:0]   side_a;

  sae_vec_cordic #(
    .STEPS (CORDIC_STEPS),
    .SIDE_W(AZ_SIDE)
  ) u_az (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v3),
    .in_x     (VW'(n3)),
    .in_y     (VW'(e3)),
    .in_side  ({id3, u3}),
    .out_valid(va),
    .out_z    (za),
    .out_mag  (maga),
    .out_side (side_a)
  );

  // Stage 4: azimuth rounding and wrap, magnitude gain partial products
  logic               v4;
  logic [7:0]         id4;
  logic signed [EW-1:0] u4;
  logic [24:0]        az4;
  logic [MPW-1:0]     mp_lo, mp_hi;
  logic signed [ZW-1:0] az_rnd;
  logic signed [26:0] az_t, az_w;

  always_comb begin
    az_rnd = za + sae_pkg::ROUND_HALF;
    az_t   = az_rnd[ZW-1:8];
    if (az_t[26]) begin
      az_w = az_t + sae_pkg::FULL_TURN_16;
    end else if (az_t >= sae_pkg::FULL_TURN_16) begin
      az_w = az_t - sae_pkg::FULL_TURN_16;
    end else begin
      az_w = az_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id4   <= side_a[AZ_SIDE-1:EW];
      u4    <= side_a[EW-1:0];
      az4   <= az_w[24:0];
      mp_lo <= MPW'(maga[HLF-1:0]) * MPW'(sae_pkg::GAIN_Q24);
      mp_hi <= MPW'(maga[2*HLF-1:HLF]) * MPW'(sae_pkg::GAIN_Q24);
    end
  end

  // Stage 5: horizontal length
  logic               v5;
  logic [7:0]         id5;
  logic signed [EW-1:0] u5;
  logic [24:0]        az5;
  logic [EW-1:0]      h5;
  logic [MPW+HLF-1:0] h_full;

  assign h_full = {mp_hi, {HLF{1'b0}}} + (MPW+HLF)'(mp_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id5 <= id4;
      u5  <= u4;
      az5 <= az4;
      h5  <= h_full[EW+23:24];
    end
  end

  // Elevation chain: atan2(up, horizontal)
  logic                 ve;
  logic signed [ZW-1:0] ze;
  logic signed [VW-1:0] mage;
  logic [EL_SIDE-1:0]   side_e;

  sae_vec_cordic #(
    .STEPS (CORDIC_STEPS),
    .SIDE_W(EL_SIDE)
  ) u_el (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v5),
    .in_x     ($signed({{(VW-EW){1'b0}}, h5})),
    .in_y     (VW'(u5)),
    .in_side  ({id5, az5}),
    .out_valid(ve),
    .out_z    (ze),
    .out_mag  (mage),
    .out_side (side_e)
  );

  // Stage 6: elevation rounding, clamp and mask compare; output register
  logic signed [ZW-1:0] el_rnd;
  logic signed [26:0]   el_t;
  logic signed [23:0]   el_c;
  logic                 mag_unused;

  assign mag_unused = ^mage;

  always_comb begin
    el_rnd = ze + sae_pkg::ROUND_HALF;
    el_t   = el_rnd[ZW-1:8];
    if (el_t > sae_pkg::RIGHT_16) begin
      el_c = sae_pkg::RIGHT_16[23:0];
    end else if (el_t < -sae_pkg::RIGHT_16) begin
      el_c = 24'(-sae_pkg::RIGHT_16);
    end else begin
      el_c = el_t[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_out.out_sat_id <= side_e[EL_SIDE-1:25];
      res_out.azimuth    <= side_e[24:0];
      res_out.elevation  <= el_c;
      res_out.visible    <= (el_c >= $signed({1'b0, mask})) || (mag_unused && 1'b0);
    end
  end

  assign res_out.valid = v6;

endmodule

`default_nettype wire
